@@ rtl/spjs_pkg.sv @@
// ----------------------------------------------------------------------------
// spjs_pkg
// shared types and constants for the sparse jacobi solver unit
// ----------------------------------------------------------------------------
package spjs_pkg;

    localparam int ROWS_MAX    = 1024;
    localparam int ENTRIES_MAX = 8192;

    localparam int ROW_AW   = $clog2(ROWS_MAX);
    localparam int ENT_AW   = $clog2(ENTRIES_MAX);
    localparam int SOL_AW   = ROW_AW + 1;
    localparam int CNT_W    = 11;
    localparam int SWEEP_W  = 16;
    localparam int IDX_W    = 14;
    localparam int COL_W    = 10;
    localparam int VAL_W    = 32;
    localparam int ACC_W    = 64;
    localparam int PADDR_W  = 3;
    localparam int IN_DW    = 160;
    localparam int OUT_DW   = 48;

    localparam logic [CNT_W-1:0] ROWS_LIMIT   = CNT_W'(ROWS_MAX);
    localparam logic [IDX_W-1:0] ENTRY_LIMIT  = IDX_W'(ENTRIES_MAX);
    localparam logic [ACC_W-1:0] NUM_CAP      = ACC_W'(64'h0000_8000_0000_0000);
    localparam logic [ACC_W-1:0] Q_POS_MAX    = ACC_W'(64'h0000_0000_7FFF_FFFF);
    localparam logic [VAL_W-1:0] SAT_POS      = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] SAT_NEG      = 32'h8000_0000;
    localparam logic [6:0]       DIV_STEPS    = 7'd64;

    localparam logic [PADDR_W-1:0] ADDR_ROW_COUNT   = 3'h0;
    localparam logic [PADDR_W-1:0] ADDR_SWEEP_COUNT = 3'h4;

    typedef enum logic [1:0] {
        ACT_LOAD_ROW   = 2'd0,
        ACT_LOAD_ENTRY = 2'd1,
        ACT_START      = 2'd2,
        ACT_READ       = 2'd3
    } action_t;

    typedef enum logic {
        KIND_DONE  = 1'b0,
        KIND_VALUE = 1'b1
    } kind_t;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_ROW_RD   = 10'b00_0000_0010,
        ST_ROW_WAIT = 10'b00_0000_0100,
        ST_ENTRY    = 10'b00_0000_1000,
        ST_DRAIN    = 10'b00_0001_0000,
        ST_PREP     = 10'b00_0010_0000,
        ST_SETUP    = 10'b00_0100_0000,
        ST_DIV      = 10'b00_1000_0000,
        ST_WRITE    = 10'b01_0000_0000,
        ST_DONE     = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic        [IDX_W-1:0] first;
        logic        [IDX_W-1:0] past;
        logic signed [VAL_W-1:0] rhs;
        logic signed [VAL_W-1:0] diag;
    } row_word_t;

    typedef struct packed {
        logic        [COL_W-1:0] column;
        logic signed [VAL_W-1:0] coeff;
    } entry_word_t;

endpackage

@@ rtl/sparse_jacobi_solver_unit.sv @@
// ----------------------------------------------------------------------------
// sparse_jacobi_solver_unit
// jacobi sweeps over a compressed-row sparse matrix in q16.16 fixed point
// ----------------------------------------------------------------------------
// channel   dir  handshake                 beat contents
// s_axis    in   s_tvalid / s_tready       tuser action, tdata row item fields
// m_axis    out  m_tvalid / m_tready       tuser kind, tdata out_row, solution
// apb       in   psel, penable, pready     row_count @0, sweep_count @4
//
// a read beat holds the input until its result has passed from the solution
// memory read register into the output register
// a start runs sweep_count sweeps over the row_count rows; each row takes the
// one-entry-per-cycle walk through the entry memory and then the
// bit-serial 64-step divider
// no clearing pass after reset; solution rows are masked by the last row count
// the output register holds a result while load beats keep being taken
// ----------------------------------------------------------------------------
module sparse_jacobi_solver_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // row, row_first, row_past, rhs, diagonal, entry, column, coeff, zero pad
    input  logic [spjs_pkg::IN_DW-1:0]    s_tdata,
    // action
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_row, solution, zero pad
    output logic [spjs_pkg::OUT_DW-1:0]   m_tdata,
    // kind
    output logic                          m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spjs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // input fields
    logic        [spjs_pkg::ROW_AW-1:0] in_row;
    logic        [spjs_pkg::IDX_W-1:0]  in_first;
    logic        [spjs_pkg::IDX_W-1:0]  in_past;
    logic signed [spjs_pkg::VAL_W-1:0]  in_rhs;
    logic signed [spjs_pkg::VAL_W-1:0]  in_diag;
    logic        [spjs_pkg::ENT_AW-1:0] in_entry;
    logic        [spjs_pkg::COL_W-1:0]  in_column;
    logic signed [spjs_pkg::VAL_W-1:0]  in_coeff;
    spjs_pkg::action_t                  in_action;

    assign in_row    = s_tdata[9:0];
    assign in_first  = s_tdata[23:10];
    assign in_past   = s_tdata[37:24];
    assign in_rhs    = s_tdata[69:38];
    assign in_diag   = s_tdata[101:70];
    assign in_entry  = s_tdata[114:102];
    assign in_column = s_tdata[124:115];
    assign in_coeff  = s_tdata[156:125];
    assign in_action = spjs_pkg::action_t'(s_tuser);

    // configuration
    logic [spjs_pkg::CNT_W-1:0]   row_count_reg;
    logic [spjs_pkg::SWEEP_W-1:0] sweep_count_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= spjs_pkg::CNT_W'(1);
            sweep_count_reg <= spjs_pkg::SWEEP_W'(1);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == spjs_pkg::ADDR_SWEEP_COUNT[2])
                sweep_count_reg <= pwdata[spjs_pkg::SWEEP_W-1:0];
            else
                row_count_reg <= pwdata[spjs_pkg::CNT_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == spjs_pkg::ADDR_SWEEP_COUNT[2])
            prdata = {16'b0, sweep_count_reg};
        else
            prdata = {21'b0, row_count_reg};
    end

    // control registers
    spjs_pkg::state_t               state_reg, state_next;
    logic                           rd_pend_reg, rd_pend_next;
    logic                           s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [spjs_pkg::CNT_W-1:0]     rows_reg;
    logic [spjs_pkg::CNT_W-1:0]     solved_rows_reg;
    logic [spjs_pkg::SWEEP_W-1:0]   sweeps_left_reg;
    logic                           bank_reg;
    logic                           first_sweep_reg;
    logic [spjs_pkg::ROW_AW-1:0]    m_reg;
    logic [spjs_pkg::IDX_W-1:0]     n_reg;
    logic [spjs_pkg::IDX_W-1:0]     end_reg;
    logic [6:0]                     div_cnt_reg;
    logic                           out_valid_reg;
    logic                           out_kind_reg;
    logic [spjs_pkg::ROW_AW-1:0]    out_row_reg;
    logic [spjs_pkg::VAL_W-1:0]     out_sol_reg;

    // datapath registers
    logic signed [spjs_pkg::VAL_W-1:0]  s2_coeff_reg;
    logic                               s2_zero_reg;
    logic signed [spjs_pkg::ACC_W-1:0]  prod_reg;
    logic        [spjs_pkg::ACC_W-1:0]  acc_reg;
    logic        [spjs_pkg::ACC_W-1:0]  num_reg;
    logic        [spjs_pkg::ACC_W-1:0]  quo_reg;
    logic        [spjs_pkg::VAL_W:0]    rem_reg;
    logic        [spjs_pkg::VAL_W-1:0]  dmag_reg;
    logic                               nneg_reg, dneg_reg, nzero_reg, dzero_reg;
    logic [spjs_pkg::ROW_AW-1:0]        rd_row_reg;
    logic                               rd_zero_reg;

    // memories
    spjs_pkg::row_word_t   row_mem [spjs_pkg::ROWS_MAX];
    spjs_pkg::entry_word_t ent_mem [spjs_pkg::ENTRIES_MAX];
    logic [spjs_pkg::VAL_W-1:0] sol_mem [2*spjs_pkg::ROWS_MAX];
    spjs_pkg::row_word_t   row_rdata_reg;
    spjs_pkg::entry_word_t ent_rdata_reg;
    logic [spjs_pkg::VAL_W-1:0] sol_rdata_reg;

    logic in_acc, out_free, pipe_busy;
    logic ent_issue, sol_rd_en, sol_wr_en;
    logic [spjs_pkg::SOL_AW-1:0] sol_rd_addr, sol_wr_addr;
    logic [spjs_pkg::VAL_W-1:0]  result;
    logic [spjs_pkg::CNT_W-1:0]  rows_clip;
    logic                        last_row;

    assign s_tready  = (state_reg == spjs_pkg::ST_IDLE) && !rd_pend_reg;
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign ent_issue = (state_reg == spjs_pkg::ST_ENTRY) && (n_reg < end_reg);
    assign rows_clip = (row_count_reg > spjs_pkg::ROWS_LIMIT) ? spjs_pkg::ROWS_LIMIT
                                                               : row_count_reg;
    assign last_row  = ({1'b0, m_reg} + spjs_pkg::CNT_W'(1)) == rows_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc && in_action == spjs_pkg::ACT_LOAD_ROW)
            row_mem[in_row] <= '{first: in_first, past: in_past, rhs: in_rhs,
                                 diag: in_diag};
        if (state_reg == spjs_pkg::ST_ROW_RD)
            row_rdata_reg <= row_mem[m_reg];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && in_action == spjs_pkg::ACT_LOAD_ENTRY)
            ent_mem[in_entry] <= '{column: in_column, coeff: in_coeff};
        if (ent_issue)
            ent_rdata_reg <= ent_mem[n_reg[spjs_pkg::ENT_AW-1:0]];
    end

    assign sol_rd_en   = s1_valid_reg || (in_acc && in_action == spjs_pkg::ACT_READ);
    assign sol_rd_addr = s1_valid_reg ? {bank_reg, ent_rdata_reg.column} : {bank_reg, in_row};
    assign sol_wr_en   = state_reg == spjs_pkg::ST_WRITE;
    assign sol_wr_addr = {!bank_reg, m_reg};

    always_ff @(posedge clk)
    begin
        if (sol_wr_en)
            sol_mem[sol_wr_addr] <= result;
        if (sol_rd_en)
            sol_rdata_reg <= sol_mem[sol_rd_addr];
    end

    // saturated, truncated quotient
    always_comb
    begin
        if (nzero_reg)
            result = '0;
        else if (dzero_reg)
            result = nneg_reg ? spjs_pkg::SAT_NEG : spjs_pkg::SAT_POS;
        else if (nneg_reg != dneg_reg)
            result = (quo_reg > spjs_pkg::Q_POS_MAX) ? spjs_pkg::SAT_NEG
                                                     : -quo_reg[spjs_pkg::VAL_W-1:0];
        else
            result = (quo_reg > spjs_pkg::Q_POS_MAX) ? spjs_pkg::SAT_POS
                                                     : quo_reg[spjs_pkg::VAL_W-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        rd_pend_next = rd_pend_reg;
        if (rd_pend_reg && out_free)
            rd_pend_next = 1'b0;
        case (state_reg)
            spjs_pkg::ST_IDLE:
            begin
                if (in_acc && in_action == spjs_pkg::ACT_READ)
                    rd_pend_next = 1'b1;
                if (in_acc && in_action == spjs_pkg::ACT_START)
                begin
                    if (rows_clip == '0 || sweep_count_reg == '0)
                        state_next = spjs_pkg::ST_DONE;
                    else
                        state_next = spjs_pkg::ST_ROW_RD;
                end
            end
            spjs_pkg::ST_ROW_RD:   state_next = spjs_pkg::ST_ROW_WAIT;
            spjs_pkg::ST_ROW_WAIT: state_next = spjs_pkg::ST_ENTRY;
            spjs_pkg::ST_ENTRY:
            begin
                if (!ent_issue)
                    state_next = spjs_pkg::ST_DRAIN;
            end
            spjs_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                    state_next = spjs_pkg::ST_PREP;
            end
            spjs_pkg::ST_PREP:  state_next = spjs_pkg::ST_SETUP;
            spjs_pkg::ST_SETUP: state_next = spjs_pkg::ST_DIV;
            spjs_pkg::ST_DIV:
            begin
                if (div_cnt_reg == spjs_pkg::DIV_STEPS - 7'd1)
                    state_next = spjs_pkg::ST_WRITE;
            end
            spjs_pkg::ST_WRITE:
            begin
                if (last_row && sweeps_left_reg == spjs_pkg::SWEEP_W'(1))
                    state_next = spjs_pkg::ST_DONE;
                else
                    state_next = spjs_pkg::ST_ROW_RD;
            end
            spjs_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = spjs_pkg::ST_IDLE;
            end
            default: state_next = spjs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= spjs_pkg::ST_IDLE;
            rd_pend_reg     <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            bank_reg        <= 1'b0;
            solved_rows_reg <= '0;
            first_sweep_reg <= 1'b1;
            rows_reg        <= '0;
            sweeps_left_reg <= '0;
            m_reg           <= '0;
            n_reg           <= '0;
            end_reg         <= '0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_pend_reg  <= rd_pend_next;
            s1_valid_reg <= ent_issue;
            s2_valid_reg <= s1_valid_reg && (ent_rdata_reg.column != m_reg);
            s3_valid_reg <= s2_valid_reg;

            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if ((rd_pend_reg || state_reg == spjs_pkg::ST_DONE) && out_free)
                out_valid_reg <= 1'b1;

            if (in_acc && in_action == spjs_pkg::ACT_START)
            begin
                rows_reg        <= rows_clip;
                sweeps_left_reg <= sweep_count_reg;
                bank_reg        <= 1'b0;
                first_sweep_reg <= 1'b1;
                m_reg           <= '0;
                solved_rows_reg <= (sweep_count_reg == '0) ? '0 : rows_clip;
            end

            if (state_reg == spjs_pkg::ST_ROW_WAIT)
            begin
                n_reg   <= row_rdata_reg.first;
                end_reg <= (row_rdata_reg.past > spjs_pkg::ENTRY_LIMIT)
                           ? spjs_pkg::ENTRY_LIMIT : row_rdata_reg.past;
            end
            if (ent_issue)
                n_reg <= n_reg + spjs_pkg::IDX_W'(1);

            if (state_reg == spjs_pkg::ST_SETUP)
                div_cnt_reg <= '0;
            else if (state_reg == spjs_pkg::ST_DIV)
                div_cnt_reg <= div_cnt_reg + 7'd1;

            if (state_reg == spjs_pkg::ST_WRITE)
            begin
                if (last_row)
                begin
                    m_reg           <= '0;
                    bank_reg        <= !bank_reg;
                    first_sweep_reg <= 1'b0;
                    sweeps_left_reg <= sweeps_left_reg - spjs_pkg::SWEEP_W'(1);
                end
                else
                    m_reg <= m_reg + spjs_pkg::ROW_AW'(1);
            end
        end
    end

    // datapath
    logic [spjs_pkg::ACC_W-1:0] nmag;
    logic [spjs_pkg::VAL_W:0]   rem_shift;

    assign nmag      = num_reg[spjs_pkg::ACC_W-1] ? -num_reg : num_reg;
    assign rem_shift = {rem_reg[spjs_pkg::VAL_W-1:0], quo_reg[spjs_pkg::ACC_W-1]};

    always_ff @(posedge clk)
    begin
        s2_coeff_reg <= ent_rdata_reg.coeff;
        s2_zero_reg  <= first_sweep_reg || ({1'b0, ent_rdata_reg.column} >= rows_reg);
        prod_reg     <= s2_coeff_reg * (s2_zero_reg ? spjs_pkg::VAL_W'(0) : $signed(sol_rdata_reg));

        if (state_reg == spjs_pkg::ST_ROW_WAIT)
            acc_reg <= '0;
        else if (s3_valid_reg)
            acc_reg <= acc_reg + spjs_pkg::ACC_W'(prod_reg >>> 16);

        if (state_reg == spjs_pkg::ST_PREP)
            num_reg <= spjs_pkg::ACC_W'(row_rdata_reg.rhs) - acc_reg;

        if (state_reg == spjs_pkg::ST_SETUP)
        begin
            nneg_reg  <= num_reg[spjs_pkg::ACC_W-1];
            nzero_reg <= num_reg == '0;
            dneg_reg  <= row_rdata_reg.diag[spjs_pkg::VAL_W-1];
            dzero_reg <= row_rdata_reg.diag == '0;
            dmag_reg  <= row_rdata_reg.diag[spjs_pkg::VAL_W-1] ? -row_rdata_reg.diag
                                                                : row_rdata_reg.diag;
            quo_reg   <= (nmag > spjs_pkg::NUM_CAP) ? (spjs_pkg::NUM_CAP << 16)
                                                    : (nmag << 16);
            rem_reg   <= '0;
        end
        else if (state_reg == spjs_pkg::ST_DIV)
        begin
            if (rem_shift >= {1'b0, dmag_reg})
            begin
                rem_reg <= rem_shift - {1'b0, dmag_reg};
                quo_reg <= {quo_reg[spjs_pkg::ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[spjs_pkg::ACC_W-2:0], 1'b0};
            end
        end

        if (in_acc && in_action == spjs_pkg::ACT_READ)
        begin
            rd_row_reg  <= in_row;
            rd_zero_reg <= {1'b0, in_row} >= solved_rows_reg;
        end

        if (rd_pend_reg && out_free)
        begin
            out_kind_reg <= spjs_pkg::KIND_VALUE;
            out_row_reg  <= rd_row_reg;
            out_sol_reg  <= rd_zero_reg ? '0 : sol_rdata_reg;
        end
        else if (state_reg == spjs_pkg::ST_DONE && out_free)
        begin
            out_kind_reg <= spjs_pkg::KIND_DONE;
            out_row_reg  <= '0;
            out_sol_reg  <= '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'b0, out_sol_reg, out_row_reg};

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == spjs_pkg::ST_IDLE)
        else $error("input taken while solver busy");

    a_div_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spjs_pkg::ST_DIV |-> !pipe_busy)
        else $error("entry pipeline active during divide");

    a_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> state_reg == spjs_pkg::ST_IDLE)
        else $error("read pending outside idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg)
        else $error("result dropped while stalled");
`endif

endmodule
